### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the triangle fragment depth test.
// Needs a clock named clk and an active-low asynchronous reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TFDT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TFDT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tfdt_pkg.sv
// Constants and types for the triangle fragment depth test.
// No dependencies; used by tfdt_div and triangle_fragment_depth_test.
`timescale 1ns / 1ps

package tfdt_pkg;

	localparam int SCREEN_WIDTH  = 512;
	localparam int SCREEN_HEIGHT = 512;
	localparam int PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = $clog2(PIX_COUNT);

	localparam int NUM_VERTS = 3;
	localparam int COORD_W   = 11;
	localparam int DEPTH_W   = 16;
	localparam int TEX_W     = 16;
	localparam int PIX_W     = 9;
	localparam int TEXEL_W   = 12;
	localparam int SIZE_W    = 13;

	// edge arithmetic
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int NUM0_W  = CROSS_W + 2;

	// weight divider: numerator <= denominator, quotient in [0, 65536]
	localparam int DIV_W      = PROD_W;
	localparam int Q_W        = 17;
	localparam int DIV_STAGES = Q_W;

	// interpolation
	localparam int ZPROD_W   = DEPTH_W + Q_W + 1;
	localparam int ZSUM_W    = ZPROD_W + 2;
	localparam int ZSH_W     = ZSUM_W - 16;
	localparam int TPROD_W   = TEX_W + Q_W;
	localparam int TSUM_W    = TPROD_W + 2;
	localparam int SCALED_W  = TSUM_W + SIZE_W;
	localparam int TEXEL_MAX = 4095;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	// register word index (paddr[2])
	localparam logic REG_TEX_WIDTH  = 1'b0;
	localparam logic REG_TEX_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0]  TEX_SIZE_RESET = 13'd1024;
	localparam logic [DEPTH_W-1:0] DEPTH_CLEAR    = 16'h8000;

	// what a pixel word carries alongside the arithmetic
	typedef struct packed {
		logic [NUM_VERTS-1:0][DEPTH_W-1:0] vz;
		logic [NUM_VERTS-1:0][TEX_W-1:0]   vu;
		logic [NUM_VERTS-1:0][TEX_W-1:0]   vv;
		logic [PIX_W-1:0]                  px;
		logic [PIX_W-1:0]                  py;
		logic [ADDR_W-1:0]                 addr;
		logic                              cov;
	} tfdt_attr_t;

	// last depth store write, for read-after-write forwarding
	typedef struct packed {
		logic               vld;
		logic [ADDR_W-1:0]  addr;
		logic [DEPTH_W-1:0] depth;
	} tfdt_fwd_t;

endpackage

### rtl/core/tfdt_div.sv
// Pipelined restoring divider for one barycentric weight: quo = floor(num * 65536 / den).
// One quotient bit per stage, DIV_STAGES stages; depends on tfdt_pkg.
`timescale 1ns / 1ps

module tfdt_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [tfdt_pkg::DIV_W-1:0] num,
	input  logic [tfdt_pkg::DIV_W-1:0] den,
	output logic [tfdt_pkg::Q_W-1:0]   quo
);
	import tfdt_pkg::*;

	logic [DIV_W-1:0] rem_s [DIV_STAGES];
	logic [DIV_W-1:0] den_s [DIV_STAGES];
	logic [Q_W-1:0]   quo_s [DIV_STAGES];

	logic [DIV_W:0]   sh   [DIV_STAGES];
	logic [DIV_W-1:0] dd   [DIV_STAGES];
	logic [Q_W-1:0]   qin  [DIV_STAGES];
	logic             ge   [DIV_STAGES];

	// first stage takes the integer bit (num == den), the rest shift in one bit each
	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				sh[k]  = {1'b0, num};
				dd[k]  = den;
				qin[k] = '0;
			end else begin
				sh[k]  = {rem_s[k-1], 1'b0};
				dd[k]  = den_s[k-1];
				qin[k] = quo_s[k-1];
			end
			ge[k] = sh[k] >= {1'b0, dd[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_s[k] <= ge[k] ? DIV_W'(sh[k] - {1'b0, dd[k]}) : DIV_W'(sh[k]);
				den_s[k] <= dd[k];
				quo_s[k] <= {qin[k][Q_W-2:0], ge[k]};
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

### rtl/core/triangle_fragment_depth_test.sv
// Triangle fragment depth test. Load words (tuser func = 0) write one vertex of the current
// triangle; pixel words (func = 1) give one result word each with coverage, texel indices,
// interpolated depth and a depth store write flag. Fully pipelined: one word per clock
// whenever the output side takes words and the depth store is not being cleared; the
// pipeline depth is set mainly by the 17-stage restoring dividers of the three barycentric
// weights. The depth store (SCREEN_WIDTH*SCREEN_HEIGHT entries, 262144 at the default size)
// is cleared to the most negative depth by a pass of one entry per cycle after reset, while
// s_tready stays low; register writes are taken as ever. Back-to-back pixels hitting the
// same store entry are handled by forwarding the last write. Texture size registers should
// only be written while the pipeline is empty.
// Depends on tfdt_pkg, tfdt_div and assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module triangle_fragment_depth_test (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // coord_x[10:0] coord_y[21:11] depth_in[37:22]
	                              // tex_u[53:38] tex_v[69:54], zero pad [71:70]
	input  logic [2:0]  s_tuser,  // func[0] vertex_slot[2:1]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // pixel_x[8:0] pixel_y[17:9] texel_x[29:18]
	                              // texel_y[41:30] frag_depth[57:42], zero pad [63:58]
	output logic [1:0]  m_tuser,  // covered[0] write_enable[1]
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tfdt_pkg::*;

	// ---------------------------------------------------------------- registers
	logic [SIZE_W-1:0] tex_w_q, tex_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q <= TEX_SIZE_RESET;
			tex_h_q <= TEX_SIZE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_TEX_WIDTH:  tex_w_q <= pwdata[SIZE_W-1:0];
				REG_TEX_HEIGHT: tex_h_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TEX_WIDTH:  prdata = 32'(tex_w_q);
			REG_TEX_HEIGHT: prdata = 32'(tex_h_q);
			default:        prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// ---------------------------------------------------------------- flow control
	// Single stall for the whole pipe: everything moves when the result register is free.
	logic adv, s_acc, clr_q;
	logic m_tvalid_q;

	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv && !clr_q;
	assign s_acc    = s_tvalid && s_tready;

	// ---------------------------------------------------------------- vertex slots
	logic signed [COORD_W-1:0] vx_q [NUM_VERTS];
	logic signed [COORD_W-1:0] vy_q [NUM_VERTS];
	logic [DEPTH_W-1:0]        vz_q [NUM_VERTS];
	logic [TEX_W-1:0]          vu_q [NUM_VERTS];
	logic [TEX_W-1:0]          vv_q [NUM_VERTS];

	// loads act at acceptance and never enter the pipe; slot 3 is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_VERTS; k++) begin
				vx_q[k] <= '0;
				vy_q[k] <= '0;
				vz_q[k] <= '0;
				vu_q[k] <= '0;
				vv_q[k] <= '0;
			end
		end else if (s_acc && s_tuser[0] == FUNC_LOAD && s_tuser[2:1] < 2'(NUM_VERTS)) begin
			vx_q[s_tuser[2:1]] <= s_tdata[10:0];
			vy_q[s_tuser[2:1]] <= s_tdata[21:11];
			vz_q[s_tuser[2:1]] <= s_tdata[37:22];
			vu_q[s_tuser[2:1]] <= s_tdata[53:38];
			vv_q[s_tuser[2:1]] <= s_tdata[69:54];
		end
	end

	// ---------------------------------------------------------------- valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s24, v_s25, v_s26;
	logic v_d [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s24 <= 1'b0;
			v_s25 <= 1'b0;
			v_s26 <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++)
				v_d[k] <= 1'b0;
		end else if (adv) begin
			v_s1  <= s_acc && s_tuser[0] == FUNC_PIXEL;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_d[0] <= v_s6;
			for (int k = 1; k < DIV_STAGES; k++)
				v_d[k] <= v_d[k-1];
			v_s24 <= v_d[DIV_STAGES-1];
			v_s25 <= v_s24;
			v_s26 <= v_s25;
		end
	end

	// ---------------------------------------------------------------- s1: pixel capture
	logic signed [COORD_W-1:0] px_s1, py_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= s_tdata[10:0];
			py_s1 <= s_tdata[21:11];
		end
	end

	// ---------------------------------------------------------------- s2: edge vectors
	logic signed [DIFF_W-1:0] ax_s2, bx_s2, cx_s2, ay_s2, by_s2, cy_s2;
	tfdt_attr_t attr_s2;
	tfdt_attr_t attr_s1c;

	always_comb begin
		for (int k = 0; k < NUM_VERTS; k++) begin
			attr_s1c.vz[k] = vz_q[k];
			attr_s1c.vu[k] = vu_q[k];
			attr_s1c.vv[k] = vv_q[k];
		end
		attr_s1c.px   = px_s1[PIX_W-1:0];
		attr_s1c.py   = py_s1[PIX_W-1:0];
		attr_s1c.addr = ADDR_W'(int'(py_s1) * SCREEN_WIDTH + int'(px_s1));
		attr_s1c.cov  = (px_s1 >= 0) && (int'(px_s1) < SCREEN_WIDTH) &&
		                (py_s1 >= 0) && (int'(py_s1) < SCREEN_HEIGHT);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2   <= DIFF_W'(vx_q[2]) - DIFF_W'(vx_q[0]);
			bx_s2   <= DIFF_W'(vx_q[1]) - DIFF_W'(vx_q[0]);
			cx_s2   <= DIFF_W'(vx_q[0]) - DIFF_W'(px_s1);
			ay_s2   <= DIFF_W'(vy_q[2]) - DIFF_W'(vy_q[0]);
			by_s2   <= DIFF_W'(vy_q[1]) - DIFF_W'(vy_q[0]);
			cy_s2   <= DIFF_W'(vy_q[0]) - DIFF_W'(py_s1);
			attr_s2 <= attr_s1c;
		end
	end

	// ---------------------------------------------------------------- s3: edge products
	logic signed [PROD_W-1:0] bxcy_s3, bycx_s3, axcy_s3, aycx_s3, axby_s3, aybx_s3;
	tfdt_attr_t attr_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			bxcy_s3 <= bx_s2 * cy_s2;
			bycx_s3 <= by_s2 * cx_s2;
			axcy_s3 <= ax_s2 * cy_s2;
			aycx_s3 <= ay_s2 * cx_s2;
			axby_s3 <= ax_s2 * by_s2;
			aybx_s3 <= ay_s2 * bx_s2;
			attr_s3 <= attr_s2;
		end
	end

	// ---------------------------------------------------------------- s4: cross product
	logic signed [CROSS_W-1:0] ux_s4, uy_s4, uz_s4;
	tfdt_attr_t attr_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s4   <= CROSS_W'(bxcy_s3) - CROSS_W'(bycx_s3);
			uy_s4   <= CROSS_W'(aycx_s3) - CROSS_W'(axcy_s3);
			uz_s4   <= CROSS_W'(axby_s3) - CROSS_W'(aybx_s3);
			attr_s4 <= attr_s3;
		end
	end

	// ---------------------------------------------------------------- s5: numerators
	logic signed [NUM0_W-1:0]  n_s5 [NUM_VERTS];
	logic signed [CROSS_W-1:0] uz_s5;
	tfdt_attr_t attr_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s5[0] <= NUM0_W'(uz_s4) - NUM0_W'(ux_s4) - NUM0_W'(uy_s4);
			n_s5[1] <= NUM0_W'(uy_s4);
			n_s5[2] <= NUM0_W'(ux_s4);
			uz_s5   <= uz_s4;
			attr_s5 <= attr_s4;
		end
	end

	// ---------------------------------------------------------------- s6: sign fix, coverage
	logic signed [NUM0_W-1:0]  nn_c [NUM_VERTS];
	logic signed [CROSS_W-1:0] uzabs_c;
	logic                      cov_c;
	tfdt_attr_t                attr_s5c;
	logic [DIV_W-1:0]          num_s6 [NUM_VERTS];
	logic [DIV_W-1:0]          den_s6;
	tfdt_attr_t attr_s6;

	always_comb begin
		uzabs_c = uz_s5[CROSS_W-1] ? -uz_s5 : uz_s5;
		cov_c   = attr_s5.cov && (uz_s5 != '0);
		for (int k = 0; k < NUM_VERTS; k++) begin
			nn_c[k] = uz_s5[CROSS_W-1] ? -n_s5[k] : n_s5[k];
			cov_c   = cov_c && !nn_c[k][NUM0_W-1];
		end
		attr_s5c     = attr_s5;
		attr_s5c.cov = cov_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_VERTS; k++)
				num_s6[k] <= DIV_W'(nn_c[k]);
			den_s6  <= DIV_W'(uzabs_c);
			attr_s6 <= attr_s5c;
		end
	end

	// ---------------------------------------------------------------- s7..s23: weights
	logic [Q_W-1:0] quo_s23 [NUM_VERTS];
	tfdt_attr_t     attr_d [DIV_STAGES];

	for (genvar g = 0; g < NUM_VERTS; g++) begin : g_div
		tfdt_div u_div (
			.clk (clk),
			.en  (adv),
			.num (num_s6[g]),
			.den (den_s6),
			.quo (quo_s23[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			attr_d[0] <= attr_s6;
			for (int k = 1; k < DIV_STAGES; k++)
				attr_d[k] <= attr_d[k-1];
		end
	end

	// ---------------------------------------------------------------- s24: weighted terms
	logic signed [ZPROD_W-1:0] zp_s24 [NUM_VERTS];
	logic [TPROD_W-1:0]        up_s24 [NUM_VERTS];
	logic [TPROD_W-1:0]        vp_s24 [NUM_VERTS];
	tfdt_attr_t attr_s24;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_VERTS; k++) begin
				zp_s24[k] <= $signed(attr_d[DIV_STAGES-1].vz[k]) * $signed({1'b0, quo_s23[k]});
				up_s24[k] <= attr_d[DIV_STAGES-1].vu[k] * quo_s23[k];
				vp_s24[k] <= attr_d[DIV_STAGES-1].vv[k] * quo_s23[k];
			end
			attr_s24 <= attr_d[DIV_STAGES-1];
		end
	end

	// ---------------------------------------------------------------- s25: sums
	logic signed [ZSUM_W-1:0] zsum_s25;
	logic [TSUM_W-1:0]        usum_s25, vsum_s25;
	tfdt_attr_t attr_s25;

	always_ff @(posedge clk) begin
		if (adv) begin
			zsum_s25 <= ZSUM_W'(zp_s24[0]) + ZSUM_W'(zp_s24[1]) + ZSUM_W'(zp_s24[2]);
			usum_s25 <= TSUM_W'(up_s24[0]) + TSUM_W'(up_s24[1]) + TSUM_W'(up_s24[2]);
			vsum_s25 <= TSUM_W'(vp_s24[0]) + TSUM_W'(vp_s24[1]) + TSUM_W'(vp_s24[2]);
			attr_s25 <= attr_s24;
		end
	end

	// ---------------------------------------------------------------- s26: depth, texel scale
	// Q1.30 to Q1.14 with floor, then saturate; texture scale is size-1, size 0 as 1.
	logic signed [ZSH_W-1:0]   zsh_c;
	logic [DEPTH_W-1:0]        z_c;
	logic [SIZE_W-1:0]         sm1_w, sm1_h;
	logic [DEPTH_W-1:0]        z_s26;
	logic [SCALED_W-1:0]       us_s26, vs_s26;
	tfdt_attr_t attr_s26;

	always_comb begin
		zsh_c = ZSH_W'(zsum_s25 >>> 16);
		if (zsh_c > ZSH_W'(32767))
			z_c = 16'h7FFF;
		else if (zsh_c < -ZSH_W'(32768))
			z_c = 16'h8000;
		else
			z_c = zsh_c[DEPTH_W-1:0];
		sm1_w = (tex_w_q == '0) ? '0 : tex_w_q - 1'b1;
		sm1_h = (tex_h_q == '0) ? '0 : tex_h_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s26    <= z_c;
			us_s26   <= usum_s25 * sm1_w;
			vs_s26   <= vsum_s25 * sm1_h;
			attr_s26 <= attr_s25;
		end
	end

	// ---------------------------------------------------------------- depth store
	logic [DEPTH_W-1:0] depth_mem [PIX_COUNT];
	logic [DEPTH_W-1:0] rd_q;
	logic [ADDR_W-1:0]  clr_cnt_q;
	tfdt_fwd_t          fwd_q;
	logic [DEPTH_W-1:0] stored_c;
	logic               item_wr;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	logic [DEPTH_W-1:0] mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ADDR_W'(PIX_COUNT - 1))
				clr_q <= 1'b0;
		end
	end

	// the word just ahead wrote at the edge this word read, so take its value on a match
	assign stored_c = (fwd_q.vld && fwd_q.addr == attr_s26.addr) ? fwd_q.depth : rd_q;
	assign item_wr  = v_s26 && attr_s26.cov && ($signed(z_s26) > $signed(stored_c));

	assign mem_we = clr_q || (adv && item_wr);
	assign mem_wa = clr_q ? clr_cnt_q : attr_s26.addr;
	assign mem_wd = clr_q ? DEPTH_CLEAR : z_s26;

	always_ff @(posedge clk) begin
		if (mem_we)
			depth_mem[mem_wa] <= mem_wd;
		if (adv)
			rd_q <= depth_mem[attr_s25.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
		end else if (adv) begin
			fwd_q.vld   <= item_wr;
			fwd_q.addr  <= attr_s26.addr;
			fwd_q.depth <= z_s26;
		end
	end

	// ---------------------------------------------------------------- result register
	logic [TEXEL_W-1:0] tx_c, ty_c;
	logic [63:0]        m_tdata_q;
	logic [1:0]         m_tuser_q;

	always_comb begin
		tx_c = (us_s26[SCALED_W-1:32] > 16'(TEXEL_MAX)) ? TEXEL_W'(TEXEL_MAX)
		                                                : us_s26[32 +: TEXEL_W];
		ty_c = (vs_s26[SCALED_W-1:32] > 16'(TEXEL_MAX)) ? TEXEL_W'(TEXEL_MAX)
		                                                : vs_s26[32 +: TEXEL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (adv)
			m_tvalid_q <= v_s26;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tuser_q <= {item_wr, attr_s26.cov};
			m_tdata_q <= {6'b0,
			              attr_s26.cov ? z_s26 : '0,
			              attr_s26.cov ? ty_c  : '0,
			              attr_s26.cov ? tx_c  : '0,
			              attr_s26.py, attr_s26.px};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// ---------------------------------------------------------------- checks
	`TFDT_ASSERT_IMP(a_clr_no_item, clr_q, !item_wr, "pixel write during store clear")
	`TFDT_ASSERT_IMP(a_we_cov, m_tvalid && m_tuser[1], m_tuser[0], "write without coverage")
	`TFDT_ASSERT_IMP(a_uncov_zero, m_tvalid && !m_tuser[0], m_tdata[57:18] == '0,
		"uncovered result carries texel or depth")
	`TFDT_ASSERT_NXT(a_fwd, adv && item_wr,
		fwd_q.vld && fwd_q.addr == $past(attr_s26.addr), "forward register missed a write")

endmodule
